@@ hdl/aes128ke_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion package
// Shared constants, S-box table, control types and the sequencer states.
// ----------------------------------------------------------------------------
package aes128ke_pkg;

  localparam int KeyWords   = 4;
  localparam int SchedWords = 44;
  localparam int WordW      = 32;
  localparam int IdxW       = 6;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SchedWords - 1);
  localparam logic [1:0]      LastLoad = 2'(KeyWords - 1);

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] RconPoly = 8'h1B;
  localparam logic [7:0] RconMsb  = 8'h80;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PUSH,
    ST_CALC
  } state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic            load;
    logic            load_done;
    logic            push;
    logic            calc;
    logic            first_byte;
    logic            last_byte;
    logic            use_g;
    logic [IdxW-1:0] idx;
  } ctl_t;

endpackage

@@ hdl/aes128ke_if.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion channel interfaces
// Valid/ready channels for key word beats and round-key word beats.
// ----------------------------------------------------------------------------
interface aes128ke_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;

  modport source (output valid, output key_word, input ready);
  modport sink   (input valid, input key_word, output ready);
endinterface

interface aes128ke_rk_if;
  logic        valid;
  logic        ready;
  logic [31:0] round_key_word;
  logic [5:0]  word_index;
  logic        last_word;

  modport source (output valid, output round_key_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input round_key_word, input word_index,
                  input last_word, output ready);
endinterface

@@ hdl/aes128_key_expansion.sv @@
// After the fourth key beat the sequencer enters ST_PUSH; once the output is free it
// registers the first round-key word. Each new word is built in four byte steps and
// each word is handed out by one push, as the byte-serial datapath has one S-box byte lane.
// The next key's beats are taken while word 43 still waits at the output.
// Reset (rst_n low, synchronous) clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
// AES-128 key expansion top level
// Four-word key window with a byte-serial schedule word generator.
// ----------------------------------------------------------------------------
module aes128_key_expansion (
  input  logic                 clk,
  input  logic                 rst_n,
  aes128ke_key_if.sink         in_key,
  aes128ke_rk_if.source        out_rk
);

  aes128ke_pkg::ctl_t ctl;

  logic [aes128ke_pkg::WordW-1:0] win_r [aes128ke_pkg::KeyWords];
  logic [aes128ke_pkg::WordW-1:0] t_r;
  logic [23:0]                    n_r;
  logic [7:0]                     rcon_r;
  logic [aes128ke_pkg::WordW-1:0] out_word_r;
  logic [aes128ke_pkg::IdxW-1:0]  out_idx_r;
  logic                           out_last_r;
  logic [7:0]                     new_byte;
  logic [7:0]                     rcon_nxt;

  aes128ke_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_key.valid),
    .in_ready  (in_key.ready),
    .out_ready (out_rk.ready),
    .out_valid (out_rk.valid),
    .ctl       (ctl)
  );

  aes128ke_byte_unit u_byte (
    .back_byte (win_r[0][31:24]),
    .prev_byte (t_r[31:24]),
    .use_g     (ctl.use_g),
    .add_rcon  (ctl.first_byte),
    .rcon      (rcon_r),
    .new_byte  (new_byte)
  );

  always_comb begin
    rcon_nxt = {rcon_r[6:0], 1'b0};
    if ((rcon_r & aes128ke_pkg::RconMsb) != 8'h00) begin
      rcon_nxt = rcon_nxt ^ aes128ke_pkg::RconPoly;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // shift key words in from the top of the window
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= in_key.key_word;
    end
    if (ctl.load_done) begin
      rcon_r <= aes128ke_pkg::RconInit;
    end
    if (ctl.push) begin
      out_word_r <= win_r[0];
      out_idx_r  <= ctl.idx;
      out_last_r <= ctl.idx == aes128ke_pkg::LastIdx;
      t_r        <= ctl.use_g ? {win_r[3][23:0], win_r[3][31:24]} : win_r[3];
    end
    if (ctl.calc) begin
      t_r <= {t_r[23:0], 8'h00};
      n_r <= {n_r[15:0], new_byte};
      if (ctl.last_byte) begin
        // advance the window by one word
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= win_r[3];
        win_r[3] <= {n_r, new_byte};
        if (ctl.use_g) begin
          rcon_r <= rcon_nxt;
        end
      end else begin
        win_r[0] <= {win_r[0][23:0], win_r[0][31:24]};
      end
    end
  end

  assign out_rk.round_key_word = out_word_r;
  assign out_rk.word_index     = out_idx_r;
  assign out_rk.last_word      = out_last_r;

endmodule

@@ hdl/aes128ke_byte_unit.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion byte unit
// One byte of a new schedule word: old byte XOR plain or substituted byte (plus rcon when asked).
// ----------------------------------------------------------------------------
module aes128ke_byte_unit (
  input  logic [7:0] back_byte,
  input  logic [7:0] prev_byte,
  input  logic       use_g,
  input  logic       add_rcon,
  input  logic [7:0] rcon,
  output logic [7:0] new_byte
);

  logic [7:0] sub_byte;

  always_comb begin
    sub_byte = aes128ke_pkg::sbox(prev_byte);
    if (use_g) begin
      new_byte = back_byte ^ sub_byte ^ (add_rcon ? rcon : 8'h00);
    end else begin
      new_byte = back_byte ^ prev_byte;
    end
  end

endmodule

@@ hdl/aes128ke_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion sequencer
// Counts key beats, schedule words and bytes; owns the output valid flag.
// ----------------------------------------------------------------------------
module aes128ke_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  output aes128ke_pkg::ctl_t     ctl
);

  aes128ke_pkg::state_t state_r, state_nxt;

  logic [1:0]                    load_cnt_r, load_cnt_nxt;
  logic [aes128ke_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic [1:0]                    byte_cnt_r, byte_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;
  logic                          in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aes128ke_pkg::ST_LOAD: begin
        if (in_valid && load_cnt_r == aes128ke_pkg::LastLoad) begin
          state_nxt = aes128ke_pkg::ST_PUSH;
        end
      end
      aes128ke_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = (idx_r == aes128ke_pkg::LastIdx) ? aes128ke_pkg::ST_LOAD
                                                       : aes128ke_pkg::ST_CALC;
        end
      end
      aes128ke_pkg::ST_CALC: begin
        if (byte_cnt_r == 2'd3) begin
          state_nxt = aes128ke_pkg::ST_PUSH;
        end
      end
      default: state_nxt = aes128ke_pkg::ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    ctl.push       = 1'b0;
    ctl.calc       = 1'b0;
    unique case (state_r)
      aes128ke_pkg::ST_LOAD: in_ready = 1'b1;
      aes128ke_pkg::ST_PUSH: ctl.push = out_free;
      aes128ke_pkg::ST_CALC: ctl.calc = 1'b1;
      default: ;
    endcase
    ctl.load       = in_fire;
    ctl.load_done  = in_fire && load_cnt_r == aes128ke_pkg::LastLoad;
    ctl.first_byte = byte_cnt_r == 2'd0;
    ctl.last_byte  = byte_cnt_r == 2'd3;
    ctl.use_g      = idx_r[1:0] == 2'd0;
    ctl.idx        = idx_r;
    out_valid      = out_valid_r;
  end

  // Counters
  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    idx_nxt       = idx_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_fire) begin
      load_cnt_nxt = load_cnt_r + 2'd1;
    end
    if (ctl.load_done) begin
      idx_nxt = '0;
    end
    if (ctl.push) begin
      out_valid_nxt = 1'b1;
      byte_cnt_nxt  = '0;
      if (idx_r == aes128ke_pkg::LastIdx) begin
        idx_nxt = '0;
      end
    end
    if (ctl.calc) begin
      byte_cnt_nxt = byte_cnt_r + 2'd1;
      if (ctl.last_byte) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes128ke_pkg::ST_LOAD;
      load_cnt_r  <= '0;
      idx_r       <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      idx_r       <= idx_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/aes128ke_checker.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion port checker
// Port-level checks on the key and round-key channels, bound to the top.
// ----------------------------------------------------------------------------
module aes128ke_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [5:0]  out_idx,
  input logic        out_last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) &&
                                $stable(out_idx) && $stable(out_last))
    else $error("result beat changed while stalled");

  // No key beat is taken while a mid-schedule result word is on offer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("key beat accepted mid-schedule");

  // Taking a key beat never exposes a fresh mid-schedule word.
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || out_last)
    else $error("result word appeared during key load");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aes128_key_expansion aes128ke_checker u_aes128ke_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_key.valid),
  .in_ready  (in_key.ready),
  .out_valid (out_rk.valid),
  .out_ready (out_rk.ready),
  .out_word  (out_rk.round_key_word),
  .out_idx   (out_rk.word_index),
  .out_last  (out_rk.last_word)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 key expansion testbench
// Streams cipher keys as four word beats and checks all 44 round-key words
// of every key, in order, against a schedule computed in the bench. The
// receiver stalls and the sender idles at several rates, and one long output
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------

// Forward S-box, index 0 leftmost.
localparam logic [0:255][7:0] FWD_SBOX = {
  8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
  8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
  8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
  8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
  8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
  8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
  8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
  8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
  8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
  8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
  8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
  8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
  8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
  8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
  8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
  8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
  8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
  8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
  8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
  8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
  8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
  8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
  8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
  8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
  8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
  8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
  8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
  8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
  8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
  8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
  8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
  8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
};

typedef struct packed {
  logic [31:0] word;
  logic [5:0]  index;
  logic        last;
} round_key_t;

class round_key_scoreboard;
  logic [31:0] key_window [4];
  logic [1:0]  key_count;
  round_key_t  pending_words [$];
  int          failures;
  int          keys_expanded;
  int          words_checked;

  function new();
    for (int i = 0; i < 4; i++) key_window[i] = '0;
    key_count     = '0;
    failures      = 0;
    keys_expanded = 0;
    words_checked = 0;
  endfunction

  function logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Collect one key beat; the fourth beat of a group expands the whole key.
  function void note_key_word(input logic [31:0] w);
    logic [31:0] sched [aes128ke_pkg::SchedWords];
    logic [31:0] t;
    logic [7:0]  rcon;
    round_key_t  rk;
    key_window[key_count] = w;
    if (key_count != aes128ke_pkg::LastLoad) begin
      key_count = key_count + 2'd1;
      return;
    end
    key_count = '0;
    keys_expanded++;
    for (int i = 0; i < 4; i++) sched[i] = key_window[i];
    rcon = aes128ke_pkg::RconInit;
    for (int i = 4; i < aes128ke_pkg::SchedWords; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = (rcon & aes128ke_pkg::RconMsb) != 0 ?
               ((rcon << 1) ^ aes128ke_pkg::RconPoly) : (rcon << 1);
      end
      sched[i] = sched[i-4] ^ t;
    end
    for (int i = 0; i < aes128ke_pkg::SchedWords; i++) begin
      rk.word  = sched[i];
      rk.index = 6'(i);
      rk.last  = (i == aes128ke_pkg::SchedWords - 1);
      pending_words.push_back(rk);
    end
  endfunction

  function void check_round_key(input logic [31:0] word, input logic [5:0] index,
                                input logic last);
    round_key_t rk;
    if (pending_words.size() == 0) begin
      $error("round_key_word: unexpected beat, word_index %0d value %h", index, word);
      failures++;
      return;
    end
    rk = pending_words.pop_front();
    words_checked++;
    if (word !== rk.word) begin
      $error("round_key_word: expected %h, actual %h", rk.word, word);
      failures++;
    end
    if (index !== rk.index) begin
      $error("word_index: expected %0d, actual %0d", rk.index, index);
      failures++;
    end
    if (last !== rk.last) begin
      $error("last_word: expected %0b, actual %0b", rk.last, last);
      failures++;
    end
  endfunction

  function int pending();
    return pending_words.size();
  endfunction
endclass

module testbench;

  localparam int KeysPerPhase   = 24;
  localparam int HoldOffCycles  = 600;
  localparam int WatchdogLimit  = 5000;
  localparam int DrainCycles    = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aes128ke_key_if key_ch ();
  aes128ke_rk_if  rk_ch ();

  aes128_key_expansion dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_key (key_ch),
    .out_rk (rk_ch)
  );

  round_key_scoreboard sched_sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int send_pcts [4]  = '{0, 76, 0, 28};
  int recv_pcts [4]  = '{0, 0, 76, 28};

  always #5 clk = ~clk;

  // Offer one key beat, idling first at the current rate; leave valid high.
  task automatic send_key_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_word <= w;
    do @(posedge clk); while (!key_ch.ready);
  endtask

  task automatic send_key(input logic [31:0] w0, input logic [31:0] w1,
                          input logic [31:0] w2, input logic [31:0] w3);
    send_key_word(w0);
    send_key_word(w1);
    send_key_word(w2);
    send_key_word(w3);
  endtask

  // Result sink: random stalls, or a long hold-off when one is requested.
  initial begin
    rk_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rk_ch.ready <= 1'b0;
      end else begin
        rk_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (key_ch.valid && key_ch.ready) sched_sb.note_key_word(key_ch.key_word);
      if (rk_ch.valid && rk_ch.ready)
        sched_sb.check_round_key(rk_ch.round_key_word, rk_ch.word_index, rk_ch.last_word);
    end
  end

  always @(posedge clk) begin
    if ((key_ch.valid && key_ch.ready) || (rk_ch.valid && rk_ch.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d words outstanding",
               quiet_cycles, sched_sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] w;
    key_ch.valid    = 1'b0;
    key_ch.key_word = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keys: extremes, the standard test key, alternating bits, and
    // last words whose rotated bytes hit the S-box entries at 0xC9 and 0xCA.
    send_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key(32'h2b7e_1516, 32'h28ae_d2a6, 32'habf7_1588, 32'h09cf_4f3c);
    send_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_key(32'h8000_0001, 32'h0102_0408, 32'h1020_4080, 32'hC9CA_C9CA);
    send_key(32'h0000_0000, 32'hFFFF_FFFF, 32'hC9CA_0080, 32'hCAC9_7F00);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (int k = 0; k < KeysPerPhase * 4; k++) begin
        case ($urandom_range(9))
          0:       w = '0;
          1:       w = '1;
          2:       w = {4{8'($urandom_range(255))}};
          3:       w = 32'h1 << $urandom_range(31);
          default: w = $urandom();
        endcase
        send_key_word(w);
      end
    end

    // Hold off the sink while the source keeps offering keys at full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 16; k++) send_key_word($urandom());
    key_ch.valid <= 1'b0;
    // let the scoreboard note the final key beat before polling it
    @(posedge clk);

    while (sched_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d keys and %0d round-key words checked", sched_sb.keys_expanded,
             sched_sb.words_checked);
    $display("under free flow, source idling, sink stalls, both, and a long sink hold-off");
    if (sched_sb.failures == 0 && sched_sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
